// File: design/apmm_pkg.sv
// ----------------------------------------------------------------------------
// Attitude PID and motor mixer package
// Shared types, widths and codes for the axis lanes, the mixer and the top.
// ----------------------------------------------------------------------------
package apmm_pkg;

  localparam int ErrW  = 17;
  localparam int GainW = 16;
  localparam int LimW  = 23;
  localparam int AccW  = 28;
  localparam int OperW = 28;
  localparam int ProdW = OperW + GainW + 1;
  localparam int SumW  = 48;
  localparam int FracW = 24;
  localparam int MotW  = 16;
  localparam int BaseW = 12;
  localparam int AltW  = 9;
  localparam int ThrW  = 10;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 23;

  localparam logic [CfgIdxW-1:0] CFG_KP        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KD        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KI        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_YAW_KP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_YAW_KD    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TIME_STEP = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INT_LIMIT = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_YAW_THR   = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_MIX
  } state_t;

  typedef enum logic [1:0] {
    STEP_PROP,
    STEP_DERIV,
    STEP_INTEG,
    STEP_KI
  } lane_step_t;

  typedef struct packed {
    logic       load;
    logic       run;
    lane_step_t step;
    logic       clr;
  } lane_ctrl_t;

  function automatic logic signed [MotW-1:0] motor_q(input logic signed [SumW-1:0] sum,
                                                     input logic off);
    logic signed [SumW-FracW-1:0] q;
    logic signed [MotW-1:0]       r;
    q = sum[SumW-1:FracW];
    if (sum[SumW-1] && (sum[FracW-1:0] != '0)) begin
      q = q + 24'sd1;
    end
    if (q > $signed(24'sd32767)) begin
      r = 16'sh7fff;
    end else if (q < $signed(-24'sd32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[MotW-1:0];
    end
    if (off) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// File: design/attitude_pid_motor_mixer_unit.sv
// ----------------------------------------------------------------------------
// Attitude PID and motor mixer
// Pitch, roll and yaw lanes run side by side; the mixer forms motor forces.
// ----------------------------------------------------------------------------
// An accepted input transaction runs the four lane steps and then the mix
// state before its result is registered as valid. A new transaction is accepted
// only after the last one is mixed, as each lane shares one multiplier across steps.
// A finished result waits in the output register while the next one runs.
// Reset clears the control state and the integral of every lane and restores defaults.
module attitude_pid_motor_mixer_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic        [apmm_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic        [apmm_pkg::CfgDatW-1:0]    cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [15:0]                     in_pitch_setpoint,
  input  logic signed [15:0]                     in_roll_setpoint,
  input  logic signed [15:0]                     in_yaw_setpoint,
  input  logic signed [15:0]                     in_pitch_angle,
  input  logic signed [15:0]                     in_roll_angle,
  input  logic signed [15:0]                     in_yaw_angle,
  input  logic signed [15:0]                     in_pitch_rate,
  input  logic signed [15:0]                     in_roll_rate,
  input  logic signed [15:0]                     in_yaw_rate,
  input  logic signed [apmm_pkg::BaseW-1:0]      in_base_thrust,
  input  logic signed [apmm_pkg::AltW-1:0]       in_altitude_correction,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [apmm_pkg::MotW-1:0]       out_motor_a,
  output logic signed [apmm_pkg::MotW-1:0]       out_motor_b,
  output logic signed [apmm_pkg::MotW-1:0]       out_motor_c,
  output logic signed [apmm_pkg::MotW-1:0]       out_motor_d,
  output logic                                   out_motors_off,
  output logic                                   out_yaw_reset
);

  logic [apmm_pkg::GainW-1:0] kp_r, kd_r, ki_r, yaw_kp_r, yaw_kd_r, ts_r;
  logic [apmm_pkg::LimW-1:0]  lim_r;
  logic [apmm_pkg::ThrW-1:0]  thr_r;

  apmm_pkg::state_t     state_r, state_nxt;
  apmm_pkg::lane_step_t step_r, step_nxt;
  apmm_pkg::lane_ctrl_t ctrl;

  logic                               in_acc, mix_ready, mix_load;
  logic signed [apmm_pkg::BaseW-1:0]  base_r;
  logic signed [apmm_pkg::AltW-1:0]   alt_r;
  logic                               off_r, yaw_on_r, yaw_on_in;
  logic signed [apmm_pkg::ErrW-1:0]   err_p, err_r, err_y, der_p, der_r, der_y;
  logic signed [apmm_pkg::SumW-1:0]   sum_p, sum_r, sum_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= 16'd6656;
      kd_r     <= 16'd1792;
      ki_r     <= 16'd51200;
      yaw_kp_r <= 16'd768;
      yaw_kd_r <= 16'd512;
      ts_r     <= 16'd131;
      lim_r    <= 23'd32768;
      thr_r    <= 10'd350;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        apmm_pkg::CFG_KP:        kp_r     <= cfg_wdata[apmm_pkg::GainW-1:0];
        apmm_pkg::CFG_KD:        kd_r     <= cfg_wdata[apmm_pkg::GainW-1:0];
        apmm_pkg::CFG_KI:        ki_r     <= cfg_wdata[apmm_pkg::GainW-1:0];
        apmm_pkg::CFG_YAW_KP:    yaw_kp_r <= cfg_wdata[apmm_pkg::GainW-1:0];
        apmm_pkg::CFG_YAW_KD:    yaw_kd_r <= cfg_wdata[apmm_pkg::GainW-1:0];
        apmm_pkg::CFG_TIME_STEP: ts_r     <= cfg_wdata[apmm_pkg::GainW-1:0];
        apmm_pkg::CFG_INT_LIMIT: lim_r    <= cfg_wdata[apmm_pkg::LimW-1:0];
        apmm_pkg::CFG_YAW_THR:   thr_r    <= cfg_wdata[apmm_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc    = in_valid && !in_stall;
  assign mix_ready = !out_valid || !out_stall;
  assign yaw_on_in = in_base_thrust
                   > $signed({{(apmm_pkg::BaseW - apmm_pkg::ThrW){1'b0}}, thr_r});

  assign err_p = {in_pitch_setpoint[15], in_pitch_setpoint}
               - {in_pitch_angle[15], in_pitch_angle};
  assign der_p = -{in_pitch_rate[15], in_pitch_rate};
  assign err_r = {in_roll_setpoint[15], in_roll_setpoint}
               + {in_roll_angle[15], in_roll_angle};
  assign der_r = {in_roll_rate[15], in_roll_rate};
  assign err_y = {in_yaw_setpoint[15], in_yaw_setpoint}
               - {in_yaw_angle[15], in_yaw_angle};
  assign der_y = -{in_yaw_rate[15], in_yaw_rate};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      apmm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = apmm_pkg::ST_RUN;
          step_nxt  = apmm_pkg::STEP_PROP;
        end
      end
      apmm_pkg::ST_RUN: begin
        step_nxt = apmm_pkg::lane_step_t'(step_r + 2'd1);
        if (step_r == apmm_pkg::STEP_KI) begin
          state_nxt = apmm_pkg::ST_MIX;
        end
      end
      apmm_pkg::ST_MIX: begin
        if (mix_ready) begin
          state_nxt = apmm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = apmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mix_load  = 1'b0;
    ctrl.load = 1'b0;
    ctrl.run  = 1'b0;
    ctrl.step = step_r;
    ctrl.clr  = 1'b0;
    case (state_r)
      apmm_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        ctrl.load = in_valid;
      end
      apmm_pkg::ST_RUN: begin
        ctrl.run = 1'b1;
      end
      apmm_pkg::ST_MIX: begin
        mix_load = mix_ready;
        ctrl.clr = mix_ready && !yaw_on_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apmm_pkg::ST_IDLE;
      step_r  <= apmm_pkg::STEP_PROP;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r   <= in_base_thrust;
      alt_r    <= in_altitude_correction;
      off_r    <= in_base_thrust[apmm_pkg::BaseW-1];
      yaw_on_r <= yaw_on_in;
    end
  end

  apmm_lane u_lane_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .err_i     (err_p),
    .deriv_i   (der_p),
    .kp        (kp_r),
    .kd        (kd_r),
    .ki        (ki_r),
    .time_step (ts_r),
    .limit     (lim_r),
    .sum       (sum_p)
  );

  apmm_lane u_lane_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .err_i     (err_r),
    .deriv_i   (der_r),
    .kp        (kp_r),
    .kd        (kd_r),
    .ki        (ki_r),
    .time_step (ts_r),
    .limit     (lim_r),
    .sum       (sum_r)
  );

  apmm_lane u_lane_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .err_i     (err_y),
    .deriv_i   (der_y),
    .kp        (yaw_kp_r),
    .kd        (yaw_kd_r),
    .ki        ({apmm_pkg::GainW{1'b0}}),
    .time_step ({apmm_pkg::GainW{1'b0}}),
    .limit     ({apmm_pkg::LimW{1'b0}}),
    .sum       (sum_y)
  );

  apmm_mixer u_mixer (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (mix_load),
    .pitch_sum      (sum_p),
    .roll_sum       (sum_r),
    .yaw_sum        (sum_y),
    .base           (base_r),
    .alt            (alt_r),
    .off            (off_r),
    .yaw_on         (yaw_on_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_motor_a    (out_motor_a),
    .out_motor_b    (out_motor_b),
    .out_motor_c    (out_motor_c),
    .out_motor_d    (out_motor_d),
    .out_motors_off (out_motors_off),
    .out_yaw_reset  (out_yaw_reset)
  );

`ifndef NO_ASSERTIONS
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == apmm_pkg::ST_RUN) && (step_r == apmm_pkg::STEP_PROP))
    else $error("accepted transaction did not start the lane sequence");

  a_last_step_mixes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apmm_pkg::ST_RUN) && (step_r == apmm_pkg::STEP_KI)
      |=> state_r == apmm_pkg::ST_MIX)
    else $error("lane sequence did not end in the mix state");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mix_load |-> (state_r == apmm_pkg::ST_MIX) && (!out_valid || !out_stall))
    else $error("result register overwritten while a result was pending");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mix_load |=> out_valid)
    else $error("mixed result not presented");

  a_off_zeroes_motors: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_motors_off) |-> (out_motor_a == '0) && (out_motor_b == '0)
      && (out_motor_c == '0) && (out_motor_d == '0))
    else $error("motors not zeroed with negative base thrust");
`endif

endmodule

// File: design/apmm_lane.sv
// ----------------------------------------------------------------------------
// Axis lane
// One PID axis: clamps its integral, then runs four multiply-accumulate
// steps on a single shared multiplier.
// ----------------------------------------------------------------------------
module apmm_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  apmm_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [apmm_pkg::ErrW-1:0]     err_i,
  input  logic signed [apmm_pkg::ErrW-1:0]     deriv_i,
  input  logic        [apmm_pkg::GainW-1:0]    kp,
  input  logic        [apmm_pkg::GainW-1:0]    kd,
  input  logic        [apmm_pkg::GainW-1:0]    ki,
  input  logic        [apmm_pkg::GainW-1:0]    time_step,
  input  logic        [apmm_pkg::LimW-1:0]     limit,
  output logic signed [apmm_pkg::SumW-1:0]     sum
);

  logic signed [apmm_pkg::ErrW-1:0]  err_r;
  logic signed [apmm_pkg::ErrW-1:0]  der_r;
  logic signed [apmm_pkg::AccW-1:0]  acc_r, acc_nxt;
  logic signed [apmm_pkg::SumW-1:0]  sum_r, sum_nxt;
  logic signed [apmm_pkg::AccW-1:0]  lim_pos, lim_neg, acc_clamped;
  logic signed [apmm_pkg::OperW-1:0] oper_a;
  logic        [apmm_pkg::GainW-1:0] oper_b;
  logic signed [apmm_pkg::ProdW-1:0] prod;
  logic signed [apmm_pkg::ProdW-1:0] prod_sh7;

  assign lim_pos = $signed({{(apmm_pkg::AccW - apmm_pkg::LimW){1'b0}}, limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (acc_r > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc_r < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc_r;
    end
  end

  always_comb begin
    case (ctrl.step)
      apmm_pkg::STEP_PROP: begin
        oper_a = {{(apmm_pkg::OperW - apmm_pkg::ErrW){err_r[apmm_pkg::ErrW-1]}}, err_r};
        oper_b = kp;
      end
      apmm_pkg::STEP_DERIV: begin
        oper_a = {{(apmm_pkg::OperW - apmm_pkg::ErrW){der_r[apmm_pkg::ErrW-1]}}, der_r};
        oper_b = kd;
      end
      apmm_pkg::STEP_INTEG: begin
        oper_a = {{(apmm_pkg::OperW - apmm_pkg::ErrW){err_r[apmm_pkg::ErrW-1]}}, err_r};
        oper_b = time_step;
      end
      default: begin
        oper_a = acc_r;
        oper_b = ki;
      end
    endcase
  end

  assign prod     = oper_a * $signed({1'b0, oper_b});
  assign prod_sh7 = prod >>> 7;

  always_comb begin
    acc_nxt = acc_r;
    sum_nxt = sum_r;
    if (ctrl.load) begin
      acc_nxt = acc_clamped;
      sum_nxt = '0;
    end else if (ctrl.run) begin
      case (ctrl.step)
        apmm_pkg::STEP_PROP,
        apmm_pkg::STEP_DERIV: begin
          sum_nxt = sum_r + $signed({prod[apmm_pkg::SumW-10:0], 9'd0});
        end
        apmm_pkg::STEP_INTEG: begin
          acc_nxt = acc_r + prod_sh7[apmm_pkg::AccW-1:0];
        end
        default: begin
          sum_nxt = sum_r + $signed({{(apmm_pkg::SumW - apmm_pkg::ProdW)
                                      {prod[apmm_pkg::ProdW-1]}}, prod});
        end
      endcase
    end else if (ctrl.clr) begin
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (ctrl.load) begin
      err_r <= err_i;
      der_r <= deriv_i;
    end
  end

  assign sum = sum_r;

endmodule

// File: design/apmm_mixer.sv
// ----------------------------------------------------------------------------
// Motor mixer
// Combines the pitch and roll outputs, and the yaw output when yaw is on, with base
// thrust and altitude correction into four motor forces and holds them in the result register.
// ----------------------------------------------------------------------------
module apmm_mixer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic signed [apmm_pkg::SumW-1:0]     pitch_sum,
  input  logic signed [apmm_pkg::SumW-1:0]     roll_sum,
  input  logic signed [apmm_pkg::SumW-1:0]     yaw_sum,
  input  logic signed [apmm_pkg::BaseW-1:0]    base,
  input  logic signed [apmm_pkg::AltW-1:0]     alt,
  input  logic                                 off,
  input  logic                                 yaw_on,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [apmm_pkg::MotW-1:0]     out_motor_a,
  output logic signed [apmm_pkg::MotW-1:0]     out_motor_b,
  output logic signed [apmm_pkg::MotW-1:0]     out_motor_c,
  output logic signed [apmm_pkg::MotW-1:0]     out_motor_d,
  output logic                                 out_motors_off,
  output logic                                 out_yaw_reset
);

  logic signed [apmm_pkg::BaseW:0]          base_alt;
  logic signed [apmm_pkg::SumW-1:0]         common, yaw_eff;
  logic signed [apmm_pkg::SumW-1:0]         sum_a, sum_b, sum_c, sum_d;
  logic                                     valid_r, valid_nxt;
  logic signed [apmm_pkg::MotW-1:0]         mot_a_r, mot_b_r, mot_c_r, mot_d_r;
  logic                                     off_r, yaw_rst_r;

  assign base_alt = {base[apmm_pkg::BaseW-1], base}
                  + {{(apmm_pkg::BaseW + 1 - apmm_pkg::AltW){alt[apmm_pkg::AltW-1]}}, alt};
  assign common   = {{(apmm_pkg::SumW - apmm_pkg::FracW - apmm_pkg::BaseW - 1)
                      {base_alt[apmm_pkg::BaseW]}}, base_alt, {apmm_pkg::FracW{1'b0}}};
  assign yaw_eff  = yaw_on ? yaw_sum : '0;

  assign sum_a = common + roll_sum - yaw_eff;
  assign sum_b = common + pitch_sum + yaw_eff;
  assign sum_c = common - roll_sum - yaw_eff;
  assign sum_d = common - pitch_sum + yaw_eff;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mot_a_r   <= apmm_pkg::motor_q(sum_a, off);
      mot_b_r   <= apmm_pkg::motor_q(sum_b, off);
      mot_c_r   <= apmm_pkg::motor_q(sum_c, off);
      mot_d_r   <= apmm_pkg::motor_q(sum_d, off);
      off_r     <= off;
      yaw_rst_r <= !yaw_on;
    end
  end

  assign out_valid      = valid_r;
  assign out_motor_a    = mot_a_r;
  assign out_motor_b    = mot_b_r;
  assign out_motor_c    = mot_c_r;
  assign out_motor_d    = mot_d_r;
  assign out_motors_off = off_r;
  assign out_yaw_reset  = yaw_rst_r;

endmodule
